// ===== design/rgb_led_fade_pwm_macros.svh =====
// Assertion macros shared by the fade PWM design files.
`ifndef RGB_LED_FADE_PWM_MACROS_SVH
`define RGB_LED_FADE_PWM_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define RLF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_led_fade_pwm assertion failed");

// Next-cycle implication, checked outside of reset.
`define RLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_led_fade_pwm assertion failed");

`endif

// ===== design/rlf_pkg.sv =====
// Package with types, constants and the brightness curve builder.
package rlf_pkg;

  localparam int COLOR_W   = 8;
  localparam int DUR_W     = 22;
  localparam int ELAPSED_W = 23;
  localparam int PWM_W     = 10;
  localparam int QUO_W     = 8;
  localparam int PROD_W    = COLOR_W + DUR_W;
  localparam int DIV_W     = DUR_W + QUO_W - 1;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int LANES     = 3;

  localparam int CURVE_DEPTH = 256;
  localparam int FRAC_BITS   = 45;
  localparam int CURVE_TOP   = 1876;
  localparam int GROWTH_NUM  = 103;
  localparam int GROWTH_DEN  = 100;

  localparam int unsigned PWM_FULL_SCALE_DEF = 1000;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET       = 2'd1,
    CMD_FADE_CUR  = 2'd2,
    CMD_FADE_FROM = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] from_red;
    logic [COLOR_W-1:0] from_green;
    logic [COLOR_W-1:0] from_blue;
    logic [DUR_W-1:0]   duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0]   pwm_red;
    logic [PWM_W-1:0]   pwm_green;
    logic [PWM_W-1:0]   pwm_blue;
    logic [COLOR_W-1:0] color_red;
    logic [COLOR_W-1:0] color_green;
    logic [COLOR_W-1:0] color_blue;
    logic               fade_active;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] elapsed;
    logic [DUR_W-1:0] length;
  } lane_ctl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [COLOR_W-1:0] color;
  } lane_stat_t;

  typedef logic [CURVE_DEPTH-1:0][PWM_W-1:0] curve_t;

  // Builds the exponential brightness table at elaboration time.
  function automatic curve_t build_curve(int unsigned full_scale);
    curve_t      tbl;
    logic [63:0] v;
    logic [63:0] ip;
    logic [63:0] base;
    logic [63:0] prod;
    v = 64'd1 << FRAC_BITS;
    for (int i = 0; i < CURVE_DEPTH; i++) begin
      ip = v >> FRAC_BITS;
      base = (ip > 64'd0) ? ip - 64'd1 : 64'd0;
      if (base > 64'(CURVE_TOP)) begin
        base = 64'(CURVE_TOP);
      end
      prod = (base * 64'(full_scale)) / 64'(CURVE_TOP);
      tbl[i] = prod[PWM_W-1:0];
      v = (v * 64'(GROWTH_NUM)) / 64'(GROWTH_DEN);
    end
    return tbl;
  endfunction

endpackage

// ===== design/rlf_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface rlf_in_if;
  import rlf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rlf_out_if;
  import rlf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/rlf_lane.sv =====
// One color channel lane: scales the fade step and divides by the fade length.
`include "rgb_led_fade_pwm_macros.svh"
module rlf_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rlf_pkg::lane_ctl_t         ctl,
  input  logic [rlf_pkg::COLOR_W-1:0] start_color,
  input  logic [rlf_pkg::COLOR_W-1:0] end_color,
  output rlf_pkg::lane_stat_t        stat
);
  import rlf_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic               neg_r, neg_nxt;
  logic [COLOR_W-1:0] base_r, base_nxt;

  logic signed [COLOR_W:0] diff;
  logic [COLOR_W-1:0]      mag;
  logic                    fits;
  logic [COLOR_W+1:0]      sum;

  assign diff = $signed({1'b0, end_color}) - $signed({1'b0, start_color});
  assign mag  = diff[COLOR_W] ? COLOR_W'(-diff) : diff[COLOR_W-1:0];
  assign fits = rem_r >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    base_nxt = base_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = PROD_W'(mag) * PROD_W'(ctl.elapsed);
      div_nxt  = {ctl.length, {(QUO_W-1){1'b0}}};
      quo_nxt  = '0;
      neg_nxt  = diff[COLOR_W];
      base_nxt = start_color;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - {1'b0, div_r};
      end
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    base_r <= base_nxt;
  end

  always_comb begin
    sum = neg_r ? ({2'b00, base_r} - {2'b00, quo_r}) : ({2'b00, base_r} + {2'b00, quo_r});
    stat.busy = busy_r;
    stat.done = done_r;
    if (sum[COLOR_W+1]) begin
      stat.color = '0;
    end else if (sum[COLOR_W]) begin
      stat.color = '1;
    end else begin
      stat.color = sum[COLOR_W-1:0];
    end
  end

  `RLF_ASSERT_IMPL(a_done_not_busy, done_r, !busy_r)
  `RLF_ASSERT_NEXT(a_start_busy, ctl.start, busy_r)
  `RLF_ASSERT_NEXT(a_last_step_done, busy_r && !ctl.start && cnt_r == '0, done_r)

endmodule

// ===== design/rgb_led_fade_pwm.sv =====
// A set command or a fade-ending tick goes from S_IDLE to S_EMIT, which loads the result.
// An interpolating tick passes through S_CALC before S_EMIT: the lanes run an
// 8-step restoring divide, one quotient bit per cycle, after the registered multiply.
// One request is worked at a time: fade commands and idle ticks are done in S_IDLE;
// other requests hold off input until S_EMIT loads the result, which waits on a pending one.
// Reset is synchronous: color zero, no fade running, no result pending.
`include "rgb_led_fade_pwm_macros.svh"
module rgb_led_fade_pwm #(
  parameter int unsigned PWM_FULL_SCALE = rlf_pkg::PWM_FULL_SCALE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rlf_in_if.sink    in_ch,
  rlf_out_if.source out_ch
);
  import rlf_pkg::*;

  localparam curve_t CURVE = build_curve(PWM_FULL_SCALE);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef logic [LANES-1:0][COLOR_W-1:0] rgb_t;

  state_t               state_r, state_nxt;
  logic                 fade_on_r, fade_on_nxt;
  rgb_t                 start_r, start_nxt;
  rgb_t                 end_r, end_nxt;
  rgb_t                 cur_r, cur_nxt;
  logic [DUR_W-1:0]     length_r, length_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [ELAPSED_W-1:0] elapsed_inc;
  rgb_t                 in_col;
  rgb_t                 in_frm;
  lane_ctl_t            lane_ctl;
  lane_stat_t [LANES-1:0] lane_stat;
  logic [LANES-1:0]     lane_done;
  rgb_t                 lane_col;

  assign in_ch.ready  = state_r == S_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign elapsed_inc = elapsed_r + ELAPSED_W'(1);
  assign in_col = {in_ch.data.blue, in_ch.data.green, in_ch.data.red};
  assign in_frm = {in_ch.data.from_blue, in_ch.data.from_green, in_ch.data.from_red};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rlf_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (lane_ctl),
      .start_color (start_r[g]),
      .end_color   (end_r[g]),
      .stat        (lane_stat[g])
    );
    assign lane_done[g] = lane_stat[g].done;
    assign lane_col[g]  = lane_stat[g].color;
  end

  always_comb begin
    state_nxt     = state_r;
    fade_on_nxt   = fade_on_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    cur_nxt       = cur_r;
    length_nxt    = length_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    lane_ctl.start   = 1'b0;
    lane_ctl.elapsed = elapsed_inc[DUR_W-1:0];
    lane_ctl.length  = length_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.data.cmd)
            CMD_SET: begin
              cur_nxt     = in_col;
              fade_on_nxt = 1'b0;
              state_nxt   = S_EMIT;
            end
            CMD_FADE_CUR, CMD_FADE_FROM: begin
              start_nxt   = (in_ch.data.cmd == CMD_FADE_CUR) ? cur_r : in_frm;
              end_nxt     = in_col;
              length_nxt  = in_ch.data.duration_ms;
              elapsed_nxt = '0;
              fade_on_nxt = 1'b1;
            end
            CMD_TICK: begin
              if (fade_on_r) begin
                elapsed_nxt = elapsed_inc;
                if (elapsed_inc <= {1'b0, length_r} && length_r != '0) begin
                  lane_ctl.start = 1'b1;
                  state_nxt      = S_CALC;
                end else begin
                  fade_on_nxt = 1'b0;
                  cur_nxt     = end_r;
                  state_nxt   = S_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CALC: begin
        if (lane_done[0]) begin
          cur_nxt   = lane_col;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.pwm_red     = CURVE[cur_r[0]];
          out_data_nxt.pwm_green   = CURVE[cur_r[1]];
          out_data_nxt.pwm_blue    = CURVE[cur_r[2]];
          out_data_nxt.color_red   = cur_r[0];
          out_data_nxt.color_green = cur_r[1];
          out_data_nxt.color_blue  = cur_r[2];
          out_data_nxt.fade_active = fade_on_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fade_on_r   <= 1'b0;
      start_r     <= '0;
      end_r       <= '0;
      cur_r       <= '0;
      length_r    <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fade_on_r   <= fade_on_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      cur_r       <= cur_nxt;
      length_r    <= length_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `RLF_ASSERT_IMPL(a_lanes_in_step, lane_done != '0, lane_done == '1 && state_r == S_CALC)
  `RLF_ASSERT_IMPL(a_calc_fade_on, state_r == S_CALC, fade_on_r && lane_stat[0].busy || lane_done[0])
  `RLF_ASSERT_NEXT(a_emit_loads, state_r == S_EMIT && !out_valid_r, out_valid_r && state_r == S_IDLE)

endmodule
